### rtl/itp_pkg.sv
// Shared types, constants and operator tables of the infix to postfix converter.
package itp_pkg;

	// Operator stack geometry
	localparam int STACK_DEPTH = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int OP_W        = 3;
	localparam int PRI_W       = 3;

	// Characters produced or recognised by the converter
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef enum logic [OP_W-1:0] {
		OP_LPAR = 3'd0,
		OP_MUL  = 3'd1,
		OP_DIV  = 3'd2,
		OP_ADD  = 3'd3,
		OP_SUB  = 3'd4,
		OP_RPAR = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_OVERFLOW = 2'd1,
		ERR_BAD_CHAR = 2'd2
	} err_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIGIT,
		ST_BAD,
		ST_HASH,
		ST_READ,
		ST_CMP,
		ST_PUSH,
		ST_TERM
	} ctl_state_t;

	// Operator lookup result
	typedef struct packed {
		logic hit;
		op_t  op;
	} op_hit_t;

	// One result item handed from the sequencer to the output register
	typedef struct packed {
		logic       valid;
		logic [7:0] ch;
		logic       last;
		err_t       err;
	} emit_t;

	// Stack memory access request
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [OP_W-1:0]   wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	function automatic op_hit_t op_lookup(input logic [7:0] c);
		op_hit_t r;
		r.hit = 1'b1;
		r.op  = OP_LPAR;
		case (c)
			8'h28: r.op = OP_LPAR;
			8'h2A: r.op = OP_MUL;
			8'h2F: r.op = OP_DIV;
			8'h2B: r.op = OP_ADD;
			8'h2D: r.op = OP_SUB;
			8'h29: r.op = OP_RPAR;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	// Stored bits back to an operator (codes above five fold as modulo six)
	function automatic op_t op_from_bits(input logic [OP_W-1:0] b);
		op_t r;
		case (b)
			3'd0: r = OP_LPAR;
			3'd1: r = OP_MUL;
			3'd2: r = OP_DIV;
			3'd3: r = OP_ADD;
			3'd4: r = OP_SUB;
			3'd5: r = OP_RPAR;
			3'd6: r = OP_LPAR;
			default: r = OP_MUL;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] op_char(input op_t op);
		logic [7:0] r;
		case (op)
			OP_LPAR: r = 8'h28;
			OP_MUL:  r = 8'h2A;
			OP_DIV:  r = 8'h2F;
			OP_ADD:  r = 8'h2B;
			OP_SUB:  r = 8'h2D;
			OP_RPAR: r = 8'h29;
			default: r = 8'h28;
		endcase
		return r;
	endfunction

	// Priority of an operator sitting on the stack
	function automatic logic [PRI_W-1:0] op_lpri(input op_t op);
		logic [PRI_W-1:0] r;
		case (op)
			OP_LPAR: r = 3'd1;
			OP_MUL:  r = 3'd5;
			OP_DIV:  r = 3'd5;
			OP_ADD:  r = 3'd3;
			OP_SUB:  r = 3'd3;
			OP_RPAR: r = 3'd6;
			default: r = 3'd1;
		endcase
		return r;
	endfunction

	// Priority of an incoming operator
	function automatic logic [PRI_W-1:0] op_rpri(input op_t op);
		logic [PRI_W-1:0] r;
		case (op)
			OP_LPAR: r = 3'd6;
			OP_MUL:  r = 3'd4;
			OP_DIV:  r = 3'd4;
			OP_ADD:  r = 3'd2;
			OP_SUB:  r = 3'd2;
			OP_RPAR: r = 3'd1;
			default: r = 3'd6;
		endcase
		return r;
	endfunction

endpackage

### rtl/itp_in_if.sv
// Input channel: one infix character or end-of-expression marker per item.
interface itp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       end_expr;

	modport source (output valid, output in_char, output end_expr, input ready);
	modport sink   (input valid, input in_char, input end_expr, output ready);
endinterface

### rtl/itp_out_if.sv
// Output channel: one postfix character with its status per item.
interface itp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last;
	logic [1:0] error_code;

	modport source (output valid, output out_char, output last, output error_code, input ready);
	modport sink   (input valid, input out_char, input last, input error_code, output ready);
endinterface

### rtl/itp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module itp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, hold data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/itp_out_stage.sv
// Output register that decouples the sequencer from a stalling receiver.
module itp_out_stage import itp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  emit_t              emit,
	output logic               free,
	itp_out_if.source          out_item
);

	logic       valid_q;
	logic [7:0] ch_q;
	logic       last_q;
	err_t       err_q;

	// Slot may be refilled when empty or being drained this cycle
	assign free = !valid_q || out_item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit.valid) begin
			valid_q <= 1'b1;
		end else if (out_item.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Load payload with each new item
	always_ff @(posedge clk) begin
		if (emit.valid) begin
			ch_q   <= emit.ch;
			last_q <= emit.last;
			err_q  <= emit.err;
		end
	end

	assign out_item.valid      = valid_q;
	assign out_item.out_char   = ch_q;
	assign out_item.last       = last_q;
	assign out_item.error_code = err_q;

endmodule

### rtl/itp_ctrl.sv
// Sequencer: classifies characters, walks the operator stack in memory, emits items.
module itp_ctrl import itp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	itp_in_if.sink          in_item,
	output ram_req_t        ram_req,
	input  logic [OP_W-1:0] ram_rdata,
	output emit_t           emit,
	input  logic            out_free
);

	ctl_state_t       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             innum_q, innum_d;
	logic [7:0]       ch_q;
	logic             end_q;
	op_t              code_q;

	logic [CNT_W-1:0] cnt_dec;
	op_hit_t          in_op;
	logic             in_digit;
	logic             in_acc;
	op_t              top_op;
	logic [PRI_W-1:0] lp;
	logic [PRI_W-1:0] rp;

	assign cnt_dec  = cnt_q - 1'b1;
	assign in_op    = op_lookup(in_item.in_char);
	assign in_digit = (in_item.in_char >= CH_ZERO) && (in_item.in_char <= CH_NINE);
	assign in_acc   = in_item.valid && in_item.ready;
	assign top_op   = op_from_bits(ram_rdata);
	assign lp       = op_lpri(top_op);
	assign rp       = op_rpri(code_q);

	// State and stack bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			innum_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			innum_q <= innum_d;
		end
	end

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ch_q   <= in_item.in_char;
			end_q  <= in_item.end_expr;
			code_q <= in_op.op;
		end
	end

	// Next state, memory access and emitted item
	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		innum_d       = innum_q;
		in_item.ready = (state_q == ST_IDLE);
		ram_req.we    = 1'b0;
		ram_req.waddr = cnt_q[ADDR_W-1:0];
		ram_req.wdata = code_q;
		ram_req.re    = 1'b0;
		ram_req.raddr = cnt_dec[ADDR_W-1:0];
		emit.valid    = 1'b0;
		emit.ch       = CH_NUL;
		emit.last     = 1'b0;
		emit.err      = ERR_NONE;

		case (state_q)
			ST_IDLE: begin
				if (in_item.valid) begin
					if (in_item.end_expr) begin
						if (innum_q) begin
							state_d = ST_HASH;
						end else if (cnt_q != '0) begin
							state_d = ST_READ;
						end else begin
							state_d = ST_TERM;
						end
					end else if (in_digit) begin
						state_d = ST_DIGIT;
					end else if (in_op.hit) begin
						if (innum_q) begin
							state_d = ST_HASH;
						end else if (cnt_q != '0) begin
							state_d = ST_READ;
						end else begin
							state_d = ST_PUSH;
						end
					end else begin
						state_d = ST_BAD;
					end
				end
			end
			ST_DIGIT: begin
				if (out_free) begin
					emit.valid = 1'b1;
					emit.ch    = ch_q;
					innum_d    = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_BAD: begin
				if (out_free) begin
					emit.valid = 1'b1;
					emit.err   = ERR_BAD_CHAR;
					state_d    = ST_IDLE;
				end
			end
			ST_HASH: begin
				// Close the number before any operator or the flush
				if (out_free) begin
					emit.valid = 1'b1;
					emit.ch    = CH_HASH;
					innum_d    = 1'b0;
					if (cnt_q != '0) begin
						state_d = ST_READ;
					end else if (end_q) begin
						state_d = ST_TERM;
					end else begin
						state_d = ST_PUSH;
					end
				end
			end
			ST_READ: begin
				// Fetch the stack top; data is ready next cycle
				ram_req.re = 1'b1;
				state_d    = ST_CMP;
			end
			ST_CMP: begin
				if (end_q) begin
					// Flush: pop and emit every entry
					if (out_free) begin
						emit.valid = 1'b1;
						emit.ch    = op_char(top_op);
						cnt_d      = cnt_dec;
						state_d    = (cnt_dec != '0) ? ST_READ : ST_TERM;
					end
				end else if (lp > rp) begin
					if (out_free) begin
						emit.valid = 1'b1;
						emit.ch    = op_char(top_op);
						cnt_d      = cnt_dec;
						state_d    = (cnt_dec != '0) ? ST_READ : ST_PUSH;
					end
				end else if (lp == rp) begin
					// Matched pair: drop both
					cnt_d   = cnt_dec;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (cnt_q >= CNT_W'(STACK_DEPTH)) begin
					if (out_free) begin
						emit.valid = 1'b1;
						emit.err   = ERR_OVERFLOW;
						state_d    = ST_IDLE;
					end
				end else begin
					ram_req.we = 1'b1;
					cnt_d      = cnt_q + 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_TERM: begin
				if (out_free) begin
					emit.valid = 1'b1;
					emit.last  = 1'b1;
					cnt_d      = '0;
					innum_d    = 1'b0;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/infix_to_postfix_converter_core.sv
// Infix to postfix converter: top level joining sequencer, stack memory and output register.
//
// in_item carries one ASCII character of an infix expression per item, or
// an end marker (end_expr = 1) that flushes the operator stack. out_item
// returns the postfix characters: digits, '#' after each number, operators,
// unmatched parentheses, and a NUL item with last = 1 closing the expression.
// An unknown character gives one NUL item with error_code 2; an operator that
// finds the stack full gives one NUL item with error_code 1 and is dropped.
// Sequence: every input item is accepted in the idle state. A digit or bad
// character passes through its own state into the output register. After
// acceptance an operator emits a closing '#' if a number is open, then for
// each stack entry it inspects reads the memory and then compares and pops,
// and finally pushes unless it closed a matched pair. The flush likewise
// emits the '#', reads and pops each stacked entry and then emits the
// terminator. The registered read of the stack memory makes the read a step
// of its own; one item is worked at a time.
// Reset clears the stack count and number flag; memory contents need none.
// When the receiver stalls, a finished item waits in the output register and
// the sequencer holds at its next emit until the register frees.
module infix_to_postfix_converter_core import itp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	itp_in_if.sink    in_item,
	itp_out_if.source out_item
);

	ram_req_t        ram_req;
	logic [OP_W-1:0] ram_rdata;
	emit_t           emit;
	logic            out_free;

	itp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.emit      (emit),
		.out_free  (out_free)
	);

	itp_ram #(
		.WIDTH (OP_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	itp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.emit     (emit),
		.free     (out_free),
		.out_item (out_item)
	);

endmodule

### rtl/itp_checker.sv
// Port-level assertions for the converter and their binding to the top level.
module itp_checker import itp_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       last,
	input logic [1:0] error_code
);

	// A stalled item keeps its valid
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output item withdrawn while stalled");

	// A stalled item keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_char) && $stable(last) && $stable(error_code))
		else $error("output payload changed while stalled");

	// The terminator is a clean NUL
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> out_char == CH_NUL && error_code == ERR_NONE)
		else $error("terminator carries data or error");

	// Error items are NUL and never close an expression
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> out_char == CH_NUL && !last)
		else $error("error item carries data or last");

	// Each accepted item is worked alone
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while previous item in work");

endmodule

bind infix_to_postfix_converter_core itp_checker u_itp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_item.valid),
	.in_ready   (in_item.ready),
	.out_valid  (out_item.valid),
	.out_ready  (out_item.ready),
	.out_char   (out_item.out_char),
	.last       (out_item.last),
	.error_code (out_item.error_code)
);
